### sv/alst_pkg.sv
// shared constants, codes and control structs for the array list unit
`default_nettype none

package alst_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int REQ_W = 2;
    localparam int ST_W  = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_POS   = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic do_insert;
        logic do_delete;
        logic load_match;
        logic pop_match;
    } alst_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
        logic             ins_pos_ok;
        logic             del_pos_ok;
        logic             match_any;
        logic             match_one;
        logic [IDX_W-1:0] match_first;
    } alst_stat_t;

    // one result for the output register
    typedef struct packed {
        logic             load;
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] match_index;
        logic [CNT_W-1:0] entry_count;
        logic             last;
    } alst_res_t;

endpackage

`default_nettype wire

### sv/alst_datapath.sv
// cell chain holding the list, entry count and search match vector
`default_nettype none

module alst_datapath
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire alst_pkg::alst_cmd_t           cmd,
    input  wire logic [alst_pkg::POS_W-1:0]    position,
    input  wire logic [alst_pkg::VAL_W-1:0]    value,
    output alst_pkg::alst_stat_t               stat
);

    logic [alst_pkg::VAL_W-1:0] cell_reg [alst_pkg::DEPTH];
    logic [alst_pkg::CNT_W-1:0] count_reg;
    logic [alst_pkg::CNT_W-1:0] count_next;
    logic [alst_pkg::DEPTH-1:0] match_reg;
    logic [alst_pkg::DEPTH-1:0] match_next;
    logic [alst_pkg::DEPTH-1:0] match_hit;
    logic [alst_pkg::DEPTH-1:0] match_rest;
    logic [alst_pkg::POS_W-1:0] pos_m1;
    logic [alst_pkg::POS_W:0]   count_p1;
    logic [alst_pkg::IDX_W-1:0] first_idx;

    assign pos_m1 = position - alst_pkg::POS_W'(1);

    for (genvar i = 0; i < alst_pkg::DEPTH; i++)
    begin : g_cell
        localparam logic [alst_pkg::POS_W-1:0] I = alst_pkg::POS_W'(i);
        logic [alst_pkg::VAL_W-1:0] from_lo;
        logic [alst_pkg::VAL_W-1:0] from_hi;

        if (i == 0)
        begin : g_lo_edge
            assign from_lo = cell_reg[i];
        end
        else
        begin : g_lo
            assign from_lo = cell_reg[i-1];
        end

        if (i == alst_pkg::DEPTH - 1)
        begin : g_hi_edge
            assign from_hi = cell_reg[i];
        end
        else
        begin : g_hi
            assign from_hi = cell_reg[i+1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.do_insert && (I >= pos_m1))
            begin
                cell_reg[i] <= (I == pos_m1) ? value : from_lo;
            end
            else if (cmd.do_delete && (I >= pos_m1))
            begin
                cell_reg[i] <= from_hi;
            end
        end

        assign match_hit[i] = (cell_reg[i] == value) &&
                              (I < alst_pkg::POS_W'(count_reg));
    end

    // lowest set bit of the match vector
    always_comb
    begin
        first_idx = '0;
        for (int k = alst_pkg::DEPTH - 1; k >= 0; k--)
        begin
            if (match_reg[k])
            begin
                first_idx = alst_pkg::IDX_W'(k);
            end
        end
    end

    assign match_rest = match_reg & (match_reg - 1'b1);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.do_delete)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (cmd.load_match)
        begin
            match_next = match_hit;
        end
        else if (cmd.pop_match)
        begin
            match_next = match_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            match_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            match_reg <= match_next;
        end
    end

    assign count_p1 = {1'b0, alst_pkg::POS_W'(count_reg)} + 1'b1;

    assign stat.count       = count_reg;
    assign stat.full        = (count_reg == alst_pkg::CNT_W'(alst_pkg::DEPTH));
    assign stat.ins_pos_ok  = (position != '0) && ({1'b0, position} <= count_p1);
    assign stat.del_pos_ok  = (position != '0) &&
                              (position <= alst_pkg::POS_W'(count_reg));
    assign stat.match_any   = |match_reg;
    assign stat.match_one   = (match_reg != '0) && (match_rest == '0);
    assign stat.match_first = first_idx;

endmodule

`default_nettype wire

### sv/alst_ctrl.sv
// request decode and search drain state machine
`default_nettype none

module alst_ctrl
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic [alst_pkg::REQ_W-1:0]    req_type,
    input  wire logic                          out_free,
    input  wire alst_pkg::alst_stat_t          stat,
    output logic                               req_ready,
    output alst_pkg::alst_cmd_t                cmd,
    output alst_pkg::alst_res_t                res
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic state_reg;
    logic state_next;
    logic req_take;

    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign req_take  = req_valid && req_ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        res             = '0;
        res.entry_count = stat.count;
        res.last        = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    unique case (req_type)
                        alst_pkg::REQ_INSERT:
                        begin
                            res.load = 1'b1;
                            if (stat.full)
                            begin
                                res.status = alst_pkg::ST_FULL;
                            end
                            else if (!stat.ins_pos_ok)
                            begin
                                res.status = alst_pkg::ST_BAD_POS;
                            end
                            else
                            begin
                                cmd.do_insert   = 1'b1;
                                res.status      = alst_pkg::ST_OK;
                                res.entry_count = stat.count + 1'b1;
                            end
                        end
                        alst_pkg::REQ_DELETE:
                        begin
                            res.load = 1'b1;
                            if (!stat.del_pos_ok)
                            begin
                                res.status = alst_pkg::ST_BAD_POS;
                            end
                            else
                            begin
                                cmd.do_delete   = 1'b1;
                                res.status      = alst_pkg::ST_OK;
                                res.entry_count = stat.count - 1'b1;
                            end
                        end
                        alst_pkg::REQ_SEARCH:
                        begin
                            cmd.load_match = 1'b1;
                            state_next     = S_SCAN;
                        end
                        default:
                        begin
                            res.load   = 1'b1;
                            res.status = alst_pkg::ST_BAD_POS;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (out_free)
                begin
                    res.load = 1'b1;
                    if (!stat.match_any)
                    begin
                        res.status = alst_pkg::ST_NOT_FOUND;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // one result per match, lowest index first
                        res.status      = alst_pkg::ST_OK;
                        res.match_index = stat.match_first;
                        res.last        = stat.match_one;
                        cmd.pop_match   = 1'b1;
                        if (stat.match_one)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### sv/array_list_insert_delete_search_unit.sv
// Ordered list of up to 64 signed 32-bit values with insert, delete and linear search.
// One request is handled at a time. Insert and delete shift the cells from the position up as
// the request is taken and register the single result at the output; a rejected request only
// registers its result. A search compares every cell in parallel when taken, then drains one
// result per cycle from the match vector while the output register is free. A new request is
// taken once the previous one has issued its last result and the output register is empty or
// being read. The store powers up undefined; only entries below the count are read.
`default_nettype none

module array_list_insert_delete_search_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // position[6:0], value[38:7], zero fill
    input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // match_index[5:0], entry_count[12:6], zero fill
    output logic [1:0]       m_axis_tuser,   // status[1:0]
    output logic             m_axis_tlast
);

    alst_pkg::alst_cmd_t  cmd;
    alst_pkg::alst_stat_t stat;
    alst_pkg::alst_res_t  res;

    logic                         out_valid_reg;
    logic [alst_pkg::ST_W-1:0]    status_reg;
    logic [alst_pkg::IDX_W-1:0]   index_reg;
    logic [alst_pkg::CNT_W-1:0]   count_out_reg;
    logic                         last_reg;
    logic                         out_free;

    assign out_free = !out_valid_reg || m_axis_tready;

    alst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_type  (s_axis_tuser),
        .out_free  (out_free),
        .stat      (stat),
        .req_ready (s_axis_tready),
        .cmd       (cmd),
        .res       (res)
    );

    alst_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .position (s_axis_tdata[6:0]),
        .value    (s_axis_tdata[38:7]),
        .stat     (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            status_reg    <= res.status;
            index_reg     <= res.match_index;
            count_out_reg <= res.entry_count;
            last_reg      <= res.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, count_out_reg, index_reg};
    assign m_axis_tuser  = status_reg;
    assign m_axis_tlast  = last_reg;

    // the entry count moves only on a taken request
    a_count_moves_on_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        (stat.count != $past(stat.count)) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("entry count changed without a request");

    // the count never exceeds the list depth
    a_count_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        stat.count <= alst_pkg::CNT_W'(alst_pkg::DEPTH))
        else $error("entry count above depth");

    // a not-found result is the only and last result with a zero index
    a_not_found_shape: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == alst_pkg::ST_NOT_FOUND))
            |-> (m_axis_tlast && (m_axis_tdata[5:0] == '0)))
        else $error("malformed not-found result");

endmodule

`default_nettype wire

### bench/testbench.sv
// self-checking bench for the array list unit: random requests against a local list model
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import alst_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int CLK_HALF   = 5;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_START = 300;
    localparam int HOLD_LEN   = 250;
    localparam int TAIL_WAIT  = 20;
    localparam logic [VAL_W-1:0] GROW_VAL = 32'h0000_0A5C;

    typedef struct {
        logic [REQ_W-1:0] kind;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
    } list_request_t;

    typedef struct {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] match_index;
        logic [CNT_W-1:0] entry_count;
        logic             last;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // position[6:0], value[38:7], zero fill
    logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // match_index[5:0], entry_count[12:6], zero fill
    logic [1:0]  m_axis_tuser;        // status[1:0]
    logic        m_axis_tlast;

    list_request_t pending_requests[$];
    list_result_t  expected_results[$];
    list_request_t request_in_flight;

    logic [VAL_W-1:0] list_model [DEPTH];
    int list_count = 0;
    int gen_count = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int ready_cycles = 0;
    int error_count = 0;
    int idle_cycles = 0;

    array_list_insert_delete_search_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    function automatic list_result_t make_result(logic [ST_W-1:0] st, int idx, logic is_last);
        list_result_t r;
        r.status      = st;
        r.match_index = IDX_W'(idx);
        r.entry_count = CNT_W'(list_count);
        r.last        = is_last;
        return r;
    endfunction

    // applies one accepted request to the list model and queues what it must produce
    task automatic predict_list_request(input list_request_t req);
        int hits[$];
        int p;
        p = int'(req.pos);
        case (req.kind)
            REQ_INSERT:
            begin
                if (list_count >= DEPTH)
                    expected_results.push_back(make_result(ST_FULL, 0, 1'b1));
                else if (p < 1 || p > list_count + 1)
                    expected_results.push_back(make_result(ST_BAD_POS, 0, 1'b1));
                else
                begin
                    for (int i = list_count; i >= p; i--)
                        list_model[i] = list_model[i-1];
                    list_model[p-1] = req.val;
                    list_count++;
                    expected_results.push_back(make_result(ST_OK, 0, 1'b1));
                end
            end
            REQ_DELETE:
            begin
                if (p < 1 || p > list_count)
                    expected_results.push_back(make_result(ST_BAD_POS, 0, 1'b1));
                else
                begin
                    for (int i = p; i < list_count; i++)
                        list_model[i-1] = list_model[i];
                    list_count--;
                    expected_results.push_back(make_result(ST_OK, 0, 1'b1));
                end
            end
            REQ_SEARCH:
            begin
                for (int i = 0; i < list_count; i++)
                    if (list_model[i] == req.val)
                        hits.push_back(i);
                if (hits.size() == 0)
                    expected_results.push_back(make_result(ST_NOT_FOUND, 0, 1'b1));
                else
                    foreach (hits[k])
                        expected_results.push_back(
                            make_result(ST_OK, hits[k], k == hits.size() - 1));
            end
            default:
                expected_results.push_back(make_result(ST_BAD_POS, 0, 1'b1));
        endcase
    endtask

    // queues a request and keeps the generator's view of the list length in step
    task automatic queue_request(logic [REQ_W-1:0] kind, int pos, logic [VAL_W-1:0] val);
        list_request_t req;
        req.kind = kind;
        req.pos  = POS_W'(pos);
        req.val  = val;
        pending_requests.push_back(req);
        if (kind == REQ_INSERT && gen_count < DEPTH && pos >= 1 && pos <= gen_count + 1)
            gen_count++;
        else if (kind == REQ_DELETE && pos >= 1 && pos <= gen_count)
            gen_count--;
    endtask

    // small value pool so that searches hit and repeat
    function automatic logic [VAL_W-1:0] pool_value();
        case ($urandom_range(0, 6))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0001;
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            5: return 32'h5A5A_A5A5;
            default: return GROW_VAL;
        endcase
    endfunction

    task automatic queue_noise();
        queue_request(REQ_W'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom());
    endtask

    task automatic queue_mixed();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            queue_request(REQ_INSERT,
                          gen_count < DEPTH ? $urandom_range(1, gen_count + 1)
                                            : $urandom_range(1, DEPTH + 1),
                          $urandom_range(0, 9) < 7 ? pool_value() : $urandom());
        else if (sel < 70)
            queue_request(REQ_DELETE, gen_count > 0 ? $urandom_range(1, gen_count) : 1, $urandom());
        else if (sel < 85)
            queue_request(REQ_SEARCH, $urandom_range(0, 127), pool_value());
        else
            queue_noise();
    endtask

    // request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin : drive_requests
            list_request_t next_req;
            logic          idle_now;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_list_request(request_in_flight);
                requests_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                idle_now = (requests_sent < 120 || requests_sent >= 200)
                           && ($urandom_range(0, 99) < 24);
                if (pending_requests.size() > 0 && !idle_now)
                begin
                    next_req          = pending_requests.pop_front();
                    request_in_flight = next_req;
                    s_axis_tdata      <= {1'b0, next_req.val, next_req.pos};
                    s_axis_tuser      <= next_req.kind;
                    s_axis_tvalid     <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin : check_results
            list_result_t want;
            ready_cycles++;
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: status %0d tdata %h",
                           m_axis_tuser, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata[5:0] !== want.match_index)
                    begin
                        $error("match_index: expected %0d, got %0d",
                               want.match_index, m_axis_tdata[5:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[12:6] !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, m_axis_tdata[12:6]);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            // long hold-off lets the unit back up into its request port
            if (ready_cycles >= HOLD_START && ready_cycles < HOLD_START + HOLD_LEN)
                m_axis_tready <= 1'b0;
            else if (results_seen >= 250 && results_seen < 350)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        // empty list corners
        queue_request(REQ_DELETE, 1, 32'h0);
        queue_request(REQ_DELETE, 0, 32'h0);
        queue_request(REQ_SEARCH, 0, 32'h0);
        queue_request(REQ_INSERT, 0, 32'h1);
        queue_request(REQ_INSERT, 2, 32'h1);
        queue_request(REQ_UNUSED, 1, 32'hFFFF_FFFF);
        // front, end and middle inserts with extreme values
        queue_request(REQ_INSERT, 1, 32'h7FFF_FFFF);
        queue_request(REQ_INSERT, 1, 32'h8000_0000);
        queue_request(REQ_INSERT, 3, 32'h0);
        queue_request(REQ_INSERT, 2, 32'hFFFF_FFFF);
        queue_request(REQ_INSERT, 127, 32'h2);
        queue_request(REQ_SEARCH, 0, 32'h7FFF_FFFF);
        queue_request(REQ_SEARCH, 127, 32'hFFFF_FFFF);
        queue_request(REQ_SEARCH, 5, 32'h0000_3039);
        queue_request(REQ_INSERT, 5, 32'h8000_0000);
        queue_request(REQ_SEARCH, 64, 32'h8000_0000);
        queue_request(REQ_DELETE, 5, 32'h0);
        queue_request(REQ_DELETE, 6, 32'h0);
        queue_request(REQ_DELETE, 1, 32'h0);
        queue_request(REQ_DELETE, 127, 32'h0);
        queue_request(REQ_UNUSED, 0, 32'h0);

        // fill the list to capacity, many entries share one value
        while (gen_count < DEPTH)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_request(REQ_SEARCH, $urandom_range(0, 127), pool_value());
            else
                queue_request(REQ_INSERT, $urandom_range(1, gen_count + 1),
                              $urandom_range(0, 1) ? GROW_VAL : pool_value());
        end
        queue_request(REQ_INSERT, 1, 32'h1);
        queue_request(REQ_INSERT, 0, 32'h1);
        queue_request(REQ_INSERT, DEPTH + 1, $urandom());
        queue_request(REQ_SEARCH, 0, GROW_VAL);
        queue_request(REQ_SEARCH, 0, pool_value());
        queue_request(REQ_DELETE, DEPTH + 1, 32'h0);
        queue_request(REQ_DELETE, DEPTH, 32'h0);
        queue_request(REQ_INSERT, DEPTH, GROW_VAL);
        queue_request(REQ_SEARCH, 0, GROW_VAL);

        repeat (120) queue_mixed();

        // drain to empty
        while (gen_count > 0)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_request(REQ_SEARCH, $urandom_range(0, 127), pool_value());
            else
                queue_request(REQ_DELETE, $urandom_range(1, gen_count), $urandom());
        end
        queue_request(REQ_DELETE, 1, 32'h0);
        queue_request(REQ_SEARCH, 0, GROW_VAL);

        while (pending_requests.size() < 360)
            queue_mixed();
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(negedge clk);
        while (!(pending_requests.size() == 0 && !s_axis_tvalid && expected_results.size() == 0)
               && idle_cycles < IDLE_LIMIT);
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            repeat (TAIL_WAIT) @(posedge clk);
            if (error_count == 0 && expected_results.size() == 0)
                $display("PASS");
            else
                $display("FAIL");
            $finish;
        end
    end

endmodule

### files.f
sv/alst_pkg.sv
sv/alst_datapath.sv
sv/alst_ctrl.sv
sv/array_list_insert_delete_search_unit.sv
bench/testbench.sv
